// ===== rtl/spm_pkg.sv =====
package spm_pkg;

   localparam int TABLE_SIZE_DEF = 32;
   localparam int WARM_EXTRA     = 8;

   localparam int VAL_W  = 31;                  // generator value / result
   localparam int GEN_W  = 32;                  // start value may reach 2^31
   localparam int MULT_W = 15;
   localparam int PROD_W = GEN_W + MULT_W;

   localparam logic [MULT_W-1:0] LCG_MULT    = 15'd16807;
   localparam logic [VAL_W-1:0]  LCG_MOD     = 31'h7FFF_FFFF;
   localparam logic [GEN_W-1:0]  SEED_OFFSET = 32'd22261048;
   localparam logic signed [31:0] SEED_HIGH  = 32'sd1000;
   localparam logic signed [31:0] SEED_LOW   = -32'sd1000;

   // p mod (2^31 - 1): fold the bits above 31 onto the low word, one correction
   function automatic logic [VAL_W-1:0] mod_fold(input logic [PROD_W-1:0] p);
      logic [GEN_W-1:0] sum;
      sum = GEN_W'(p[PROD_W-1:VAL_W]) + GEN_W'(p[VAL_W-1:0]);
      if (sum >= GEN_W'(LCG_MOD)) begin
         sum = sum - GEN_W'(LCG_MOD);
      end
      return sum[VAL_W-1:0];
   endfunction

endpackage

// ===== rtl/shuffled_park_miller_rng_core.sv =====
// Path: a taken request runs ST_SMUL, ST_SRED and ST_SWB before its word is registered, after any warm-up.
// A new request is taken only in ST_IDLE, after the step multiply, the table read and the write-back.
// Warm-up (on the first request after reset or a seed write): 40 generator steps, one
// multiply and one modular fold per step, writing the last TABLE_SIZE into the table.
// Reset (synchronous, active high) folds seed 0, arms the warm-up, clears the last word.
module shuffled_park_miller_rng_core
   import spm_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [0] request
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [30:0] random_value
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data   // seed, signed
);

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam int CNT_W = $clog2(TABLE_SIZE + WARM_EXTRA);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_WMUL = 6'b000010,
      ST_WRED = 6'b000100,
      ST_SMUL = 6'b001000,
      ST_SRED = 6'b010000,
      ST_SWB  = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   logic [GEN_W-1:0] gen_ff, gen_in;
   logic             pend_ff, pend_in;
   logic [VAL_W-1:0] last_ff, last_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] rsp_data_ff, rsp_data_in;

   logic             req_accept;
   logic             warm_needed;
   logic             commit;
   logic             lcg_mul_en;
   logic [VAL_W-1:0] lcg_next;
   logic [IDX_W-1:0] bucket_idx;
   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   logic [VAL_W-1:0] ram_wr_data;
   logic             ram_rd_en;
   logic [VAL_W-1:0] ram_rd_data;
   logic signed [31:0] seed;
   logic [GEN_W-1:0] seed_mag;

   spm_lcg u_lcg (
      .clock  (clock),
      .mul_en (lcg_mul_en),
      .gen_i  (gen_ff),
      .next_o (lcg_next)
   );

   spm_bucket #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_bucket (
      .clock  (clock),
      .mul_en (state_ff == ST_SMUL),
      .last_i (last_ff),
      .idx_o  (bucket_idx)
   );

   spm_ram #(
      .WIDTH (VAL_W),
      .DEPTH (TABLE_SIZE)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (bucket_idx),
      .rd_data (ram_rd_data)
   );

   assign req_tready  = (state_ff == ST_IDLE);
   assign req_accept  = req_tvalid && req_tready && req_tdata[0];
   assign warm_needed = pend_ff || (gen_ff == '0) || (last_ff == '0);
   assign commit      = (state_ff == ST_SWB) && (!rsp_valid_ff || rsp_tready);
   assign lcg_mul_en  = (state_ff == ST_WMUL) || (state_ff == ST_SMUL);
   assign ram_rd_en   = (state_ff == ST_SRED);

   // seed mapped to a positive generator start value, stored as is
   assign seed = csr_wr_data;
   always_comb begin
      if (seed > SEED_HIGH) begin
         seed_mag = csr_wr_data;
      end else if (seed > SEED_LOW) begin
         seed_mag = SEED_OFFSET - csr_wr_data;
      end else begin
         seed_mag = ~csr_wr_data + GEN_W'(1);
      end
   end

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = cnt_ff[IDX_W-1:0];
      ram_wr_data = lcg_next;
      if ((state_ff == ST_WRED) && (cnt_ff < CNT_W'(TABLE_SIZE))) begin
         ram_wr_en = 1'b1;
      end else if (commit) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = idx_ff;
         ram_wr_data = gen_ff[VAL_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      gen_in       = gen_ff;
      pend_in      = pend_ff;
      last_in      = last_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (warm_needed) begin
                  gen_in   = pend_ff ? gen_ff : GEN_W'(1);
                  cnt_in   = CNT_W'(TABLE_SIZE + WARM_EXTRA - 1);
                  state_in = ST_WMUL;
               end else begin
                  state_in = ST_SMUL;
               end
            end
         end
         ST_WMUL: begin
            state_in = ST_WRED;
         end
         ST_WRED: begin
            gen_in = GEN_W'(lcg_next);
            if (cnt_ff == '0) begin
               last_in  = lcg_next;
               pend_in  = 1'b0;
               state_in = ST_SMUL;
            end else begin
               cnt_in   = cnt_ff - CNT_W'(1);
               state_in = ST_WMUL;
            end
         end
         ST_SMUL: begin
            state_in = ST_SRED;
         end
         ST_SRED: begin
            gen_in   = GEN_W'(lcg_next);
            idx_in   = bucket_idx;
            state_in = ST_SWB;
         end
         ST_SWB: begin
            // hold until the output register is free
            if (commit) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = ram_rd_data;
               last_in      = ram_rd_data;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_wr_en) begin
         gen_in  = seed_mag;
         pend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gen_ff       <= SEED_OFFSET;
         pend_ff      <= 1'b1;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_ff       <= gen_in;
         pend_ff      <= pend_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

`ifndef SYNTH
   a_word_from_writeback: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_SWB))
      else $error("result word raised outside write-back");

   a_serve_after_warm: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SMUL) |-> !pend_ff)
      else $error("serving with warm-up still pending");

   a_index_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SRED) |-> (32'(bucket_idx) < 32'(TABLE_SIZE)))
      else $error("bucket index beyond table");

   a_warm_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_accept && warm_needed && !csr_wr_en) |=>
         (state_ff == ST_WMUL && cnt_ff == CNT_W'(TABLE_SIZE + WARM_EXTRA - 1)))
      else $error("warm-up did not start at full count");
`endif

endmodule

// ===== rtl/spm_ram.sv =====
module spm_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/spm_lcg.sv =====
module spm_lcg
   import spm_pkg::*;
(
   input  logic             clock,
   input  logic             mul_en,
   input  logic [GEN_W-1:0] gen_i,
   output logic [VAL_W-1:0] next_o
);

   logic [PROD_W-1:0] prod_in;
   logic [PROD_W-1:0] prod_ff;

   assign prod_in = PROD_W'(gen_i) * PROD_W'(LCG_MULT);

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // reduce in the cycle after the multiply
   assign next_o = mod_fold(prod_ff);

endmodule

// ===== rtl/spm_bucket.sv =====
module spm_bucket
   import spm_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
   input  logic                          clock,
   input  logic                          mul_en,
   input  logic [VAL_W-1:0]              last_i,
   output logic [$clog2(TABLE_SIZE)-1:0] idx_o
);

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam logic [63:0] BUCKET = 64'd1 + (64'(LCG_MOD) - 64'd1) / 64'(TABLE_SIZE);
   // reciprocal scaled so the error stays below 1/BUCKET for any 31-bit value
   localparam int SHIFT = VAL_W + $clog2(BUCKET);
   localparam logic [63:0] RECIP = ((64'd1 << SHIFT) / BUCKET) + 64'd1;

   logic [63:0] prod_in;
   logic [63:0] prod_ff;
   logic [63:0] quot;

   assign prod_in = 64'(last_i) * RECIP;

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
   end

   assign quot = prod_ff >> SHIFT;

   // clamp the top bucket onto the last entry
   assign idx_o = (quot >= 64'(TABLE_SIZE)) ? IDX_W'(TABLE_SIZE - 1) : quot[IDX_W-1:0];

endmodule
